// ===== design/gfca_pkg.sv =====
// ============================================================================
// gfca_pkg
// Shared constants and types for the gated frequency counter with text readout.
// ============================================================================
`default_nettype none

package gfca_pkg;

  // Width of the edge counter and number of decimal digits in the readout.
  localparam int COUNT_WIDTH = 16;
  localparam int MAX_DIGITS  = 5;

  // Derived widths for the serial converter and the digit sequencer.
  localparam int BCD_W     = 4 * MAX_DIGITS;
  localparam int BIT_CNT_W = $clog2(COUNT_WIDTH);
  localparam int DIG_CNT_W = $clog2(MAX_DIGITS);

  // The window length resets to the timer preload complement.
  localparam logic [15:0] GATE_PRELOAD = 16'hC2F7;
  localparam logic [15:0] GATE_RESET   = 16'hFFFF - GATE_PRELOAD + 16'd1;

  // Readout characters.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // Configuration register indexes.
  localparam logic [0:0] REG_GATE = 1'b0;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_COUNT = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_DIGIT = 6'b000100,
    ST_SPACE = 6'b001000,
    ST_H     = 6'b010000,
    ST_Z     = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== design/gated_frequency_counter_ascii_top.sv =====
// ============================================================================
// gated_frequency_counter_ascii_top
// Gated edge counter that prints each window's count as decimal text + " Hz".
// ============================================================================
// A tick item is taken every cycle while the window is open. On the
// closing tick, the bit-serial converter runs, then the sequencer steps through
// each digit position (MAX_DIGITS) and the three characters of " Hz", stalled by out_ready.
// No tick is taken from the closing tick until the trailing 'z' is loaded for output.
// Reset (rst, synchronous, active high) clears both counters, the sequencer
// and the output valid, and loads the window length with 15625.
`default_nettype none

module gated_frequency_counter_ascii_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        edge_req,
  // Readout channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       char_code,
  output logic             last,
  output logic [15:0]      count_value,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  gfca_pkg::state_t state;

  logic [15:0]                          gate_ticks;
  logic [gfca_pkg::COUNT_WIDTH-1:0]     edge_count;
  logic [15:0]                          tick_count;
  logic [gfca_pkg::COUNT_WIDTH-1:0]     latched;
  logic [gfca_pkg::COUNT_WIDTH-1:0]     bin;
  logic [gfca_pkg::BCD_W-1:0]           bcd;
  logic [gfca_pkg::BIT_CNT_W-1:0]       bit_cnt;
  logic [gfca_pkg::DIG_CNT_W-1:0]       dig_cnt;
  logic                                 started;

  logic                                 in_fire;
  logic                                 slot_free;
  logic [gfca_pkg::COUNT_WIDTH-1:0]     edge_next;
  logic [15:0]                          tick_next;
  logic                                 closing;
  logic [gfca_pkg::BCD_W-1:0]           bcd_adj;
  logic [3:0]                           top_digit;
  logic                                 show_digit;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == gfca_pkg::REG_GATE) ? {16'd0, gate_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_ticks <= gfca_pkg::GATE_RESET;
    end else if (psel && penable && pwrite && paddr[2:2] == gfca_pkg::REG_GATE) begin
      gate_ticks <= pwdata[15:0];
    end
  end

  // Handshake helpers.
  assign in_ready  = (state == gfca_pkg::ST_COUNT);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Counter update and window close test. A zero gate closes on wrap.
  always_comb begin
    edge_next = edge_count + gfca_pkg::COUNT_WIDTH'(edge_req);
    tick_next = tick_count + 16'd1;
    if (gate_ticks == 16'd0) begin
      closing = (tick_next == 16'd0);
    end else begin
      closing = (tick_next >= gate_ticks);
    end
  end

  // Add-three correction of every BCD digit before the next shift.
  always_comb begin
    for (int i = 0; i < gfca_pkg::MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Leading zeros are skipped; the last digit position is always shown.
  assign top_digit  = bcd[gfca_pkg::BCD_W-1 -: 4];
  assign show_digit = started || (top_digit != 4'd0) || (dig_cnt == '0);

  // Sequencer, counters and converter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gfca_pkg::ST_COUNT;
      edge_count <= '0;
      tick_count <= '0;
      bit_cnt    <= '0;
      dig_cnt    <= '0;
      started    <= 1'b0;
    end else begin
      unique case (state)
        gfca_pkg::ST_COUNT: begin
          if (in_fire) begin
            if (closing) begin
              latched    <= edge_next;
              bin        <= edge_next;
              bcd        <= '0;
              bit_cnt    <= gfca_pkg::BIT_CNT_W'(gfca_pkg::COUNT_WIDTH - 1);
              edge_count <= '0;
              tick_count <= '0;
              state      <= gfca_pkg::ST_CONV;
            end else begin
              edge_count <= edge_next;
              tick_count <= tick_next;
            end
          end
        end
        gfca_pkg::ST_CONV: begin
          // One binary bit enters the BCD register per cycle.
          bcd <= {bcd_adj[gfca_pkg::BCD_W-2:0], bin[gfca_pkg::COUNT_WIDTH-1]};
          bin <= {bin[gfca_pkg::COUNT_WIDTH-2:0], 1'b0};
          if (bit_cnt == '0) begin
            dig_cnt <= gfca_pkg::DIG_CNT_W'(gfca_pkg::MAX_DIGITS - 1);
            started <= 1'b0;
            state   <= gfca_pkg::ST_DIGIT;
          end else begin
            bit_cnt <= bit_cnt - gfca_pkg::BIT_CNT_W'(1);
          end
        end
        gfca_pkg::ST_DIGIT: begin
          // One digit leaves the top of the BCD register per step.
          if (slot_free) begin
            bcd <= {bcd[gfca_pkg::BCD_W-5:0], 4'd0};
            if (show_digit) begin
              started <= 1'b1;
            end
            if (dig_cnt == '0) begin
              state <= gfca_pkg::ST_SPACE;
            end else begin
              dig_cnt <= dig_cnt - gfca_pkg::DIG_CNT_W'(1);
            end
          end
        end
        gfca_pkg::ST_SPACE: begin
          if (slot_free) begin
            state <= gfca_pkg::ST_H;
          end
        end
        gfca_pkg::ST_H: begin
          if (slot_free) begin
            state <= gfca_pkg::ST_Z;
          end
        end
        gfca_pkg::ST_Z: begin
          if (slot_free) begin
            state <= gfca_pkg::ST_COUNT;
          end
        end
        default: begin
          state <= gfca_pkg::ST_COUNT;
        end
      endcase
    end
  end

  // Output register: loaded whenever the sequencer emits a character item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free && state == gfca_pkg::ST_DIGIT && show_digit) begin
      out_valid   <= 1'b1;
      char_code   <= gfca_pkg::CH_ZERO | {4'd0, top_digit};
      last        <= 1'b0;
      count_value <= 16'(latched);
    end else if (slot_free && state == gfca_pkg::ST_SPACE) begin
      out_valid   <= 1'b1;
      char_code   <= gfca_pkg::CH_SPACE;
      last        <= 1'b0;
      count_value <= 16'(latched);
    end else if (slot_free && state == gfca_pkg::ST_H) begin
      out_valid   <= 1'b1;
      char_code   <= gfca_pkg::CH_H;
      last        <= 1'b0;
      count_value <= 16'(latched);
    end else if (slot_free && state == gfca_pkg::ST_Z) begin
      out_valid   <= 1'b1;
      char_code   <= gfca_pkg::CH_Z;
      last        <= 1'b1;
      count_value <= 16'(latched);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // A closing tick starts the conversion and stops taking ticks.
  a_close_to_conv: assert property (@(posedge clk) disable iff (rst)
    in_fire && closing |=> state == gfca_pkg::ST_CONV && !in_ready)
    else $error("closing tick did not start conversion");

  // The last flag marks the trailing 'z' and nothing else.
  a_last_is_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> char_code == gfca_pkg::CH_Z)
    else $error("last set on a character other than z");

  a_z_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> char_code != gfca_pkg::CH_Z)
    else $error("z emitted without last");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_gated_frequency_counter_ascii_top.sv =====
// ============================================================================
// tb_gated_frequency_counter_ascii_top
// Self-checking bench for the gated edge counter with its " Hz" text readout.
// Each tick item is run through an in-bench model of the gate window and the
// decimal spelling, and every readout character is compared with the oldest
// character still owed. Window lengths are programmed over APB between phases.
// ============================================================================

module tb_gated_frequency_counter_ascii_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LONG_HOLD     = 300;
  localparam int          SETTLE        = 40;
  localparam logic [15:0] GATE_AT_RESET = 16'd15625;
  localparam int          REG_SPARE     = 1;
  localparam logic [2:0]  GATE_ADDR     = 3'(gfca_pkg::REG_GATE) << 2;
  localparam logic [2:0]  SPARE_ADDR    = 3'(REG_SPARE) << 2;

  typedef struct packed {
    logic [7:0]  code;
    logic        last_flag;
    logic [15:0] count;
  } readout_char_t;

  // Tracks the gate window and the readout characters still owed.
  class readout_tracker;
    logic [15:0]                      gate_len;
    logic [gfca_pkg::COUNT_WIDTH-1:0] edge_tally;
    logic [15:0]                      tick_tally;
    readout_char_t                    pending_chars[$];

    function new();
      gate_len   = GATE_AT_RESET;
      edge_tally = '0;
      tick_tally = '0;
    endfunction

    function void set_gate(logic [15:0] value);
      gate_len = value;
    endfunction

    function int waiting();
      return pending_chars.size();
    endfunction

    function void queue_char(logic [7:0] code, logic last_flag, logic [15:0] count);
      readout_char_t rc;
      rc.code      = code;
      rc.last_flag = last_flag;
      rc.count     = count;
      pending_chars.push_back(rc);
    endfunction

    // One accepted tick: count the edge, advance the gate, spell a closed window.
    function void note_tick(logic edge_seen);
      logic [gfca_pkg::COUNT_WIDTH-1:0] latched;
      logic [gfca_pkg::COUNT_WIDTH-1:0] rest;
      int                               digs[gfca_pkg::MAX_DIGITS];
      int                               nd;
      bit                               closing;
      if (edge_seen) edge_tally = edge_tally + gfca_pkg::COUNT_WIDTH'(1);
      tick_tally = tick_tally + 16'd1;
      // A zero gate lets the tick counter wrap all the way around.
      closing = (gate_len == 16'd0) ? (tick_tally == 16'd0) : (tick_tally >= gate_len);
      if (!closing) return;
      latched    = edge_tally;
      edge_tally = '0;
      tick_tally = '0;
      // Lowest digit first, at least one digit, truncated to the display width.
      rest = latched;
      nd   = 0;
      do begin
        digs[nd] = int'(rest % 10);
        rest     = gfca_pkg::COUNT_WIDTH'(rest / 10);
        nd++;
      end while (rest != 0 && nd < gfca_pkg::MAX_DIGITS);
      while (nd > 1 && digs[nd-1] == 0) nd--;
      for (int i = nd - 1; i >= 0; i--)
        queue_char(gfca_pkg::CH_ZERO | 8'(digs[i]), 1'b0, 16'(latched));
      queue_char(gfca_pkg::CH_SPACE, 1'b0, 16'(latched));
      queue_char(gfca_pkg::CH_H, 1'b0, 16'(latched));
      queue_char(gfca_pkg::CH_Z, 1'b1, 16'(latched));
    endfunction

    // Returns an empty string when the character is the one owed next.
    function string match_char(logic [7:0] code, logic last_flag, logic [15:0] count);
      readout_char_t want;
      if (pending_chars.size() == 0)
        return $sformatf("unexpected char 0x%02h last %0b count %0d", code, last_flag, count);
      want = pending_chars.pop_front();
      if (code !== want.code || last_flag !== want.last_flag || count !== want.count)
        return $sformatf("char 0x%02h last %0b count %0d, expected 0x%02h last %0b count %0d",
                         code, last_flag, count, want.code, want.last_flag, want.count);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        edge_req;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  char_code;
  logic        last;
  logic [15:0] count_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  readout_tracker expected_readout = new();
  int             mismatches = 0;
  bit             quiet = 1'b0;
  bit             hold_off_req = 1'b0;

  gated_frequency_counter_ascii_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .edge_req   (edge_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .last       (last),
    .count_value(count_value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2ms;
    $display("** gated_frequency_counter_ascii_top: FAILED **");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Both channels are sampled here: tick items first, then readout items.
  always @(posedge clk) begin
    string msg;
    if (!rst) begin
      if (in_valid && in_ready) expected_readout.note_tick(edge_req);
      if (out_valid && out_ready) begin
        msg = expected_readout.match_char(char_code, last, count_value);
        if (msg != "") flag_mismatch(msg);
      end
    end
  end

  // Readout receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads the window length back and compares it with the tracked value.
  task automatic verify_gate();
    logic [31:0] got;
    apb_read(GATE_ADDR, got);
    if (got !== {16'd0, expected_readout.gate_len})
      flag_mismatch($sformatf("gate_ticks read 0x%08h, expected 0x%04h", got,
                              expected_readout.gate_len));
  endtask

  task automatic program_gate(input logic [15:0] value);
    apb_write(GATE_ADDR, {16'd0, value});
    expected_readout.set_gate(value);
    verify_gate();
  endtask

  // Offers one tick item and holds it until it is taken.
  task automatic send_tick(input logic edge_seen);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    edge_req <= edge_seen;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_ticks(input int n, input int edge_pct);
    for (int i = 0; i < n; i++) send_tick($urandom_range(0, 99) < edge_pct);
  endtask

  // Stops offering ticks and waits until every owed character has come out.
  // The first edge lets the sampler take in the last accepted tick.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readout.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    in_valid = 1'b0;
    edge_req = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset window length, and a write to an unmapped register changes nothing.
    verify_gate();
    apb_write(SPARE_ADDR, 32'd7);
    verify_gate();

    // A partial window at the reset length; it stays open.
    run_ticks(12, 75);
    quiesce();

    // Shortest window: the first tick closes the partial window, then every
    // tick closes its own.
    program_gate(16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    quiesce();

    // A count with a trailing zero, then an empty window.
    program_gate(16'd10);
    run_ticks(10, 100);
    run_ticks(10, 0);
    quiesce();

    // Gate lowered mid-window: the next tick closes the window at once.
    program_gate(16'd40);
    run_ticks(6, 100);
    quiesce();
    program_gate(16'd3);
    send_tick(1'b1);
    quiesce();

    // A zero gate keeps the window open; a short gate then closes it.
    program_gate(16'd0);
    run_ticks(40, 50);
    quiesce();
    program_gate(16'd5);
    send_tick(1'b1);
    quiesce();

    // Random part. The first setting runs under a long receiver hold-off.
    program_gate(16'd1);
    hold_off_req = 1'b1;
    run_ticks(60, $urandom_range(10, 90));
    quiesce();
    program_gate(16'd2);
    run_ticks(60, $urandom_range(10, 90));
    quiesce();
    program_gate(16'($urandom_range(4, 30)));
    run_ticks(80, $urandom_range(5, 95));
    quiesce();
    program_gate(16'($urandom_range(60, 150)));
    run_ticks(110, $urandom_range(50, 100));
    quiesce();

    // Closing stretch with no idling on either side.
    quiet = 1'b1;
    program_gate(16'($urandom_range(3, 9)));
    run_ticks(30, 80);
    quiesce();

    if (expected_readout.waiting() != 0)
      flag_mismatch($sformatf("%0d readout chars never arrived", expected_readout.waiting()));
    if (mismatches == 0) begin
      $display("** gated_frequency_counter_ascii_top: PASSED **");
    end else begin
      $display("** gated_frequency_counter_ascii_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gfca_pkg.sv
design/gated_frequency_counter_ascii_top.sv
bench/tb_gated_frequency_counter_ascii_top.sv
